>>> sv/lcbc_pkg.sv
// ---------------------------------------------------------------------------
// lcbc_pkg
// shared types, widths and helper functions for the luhn card brand check
// ---------------------------------------------------------------------------
package lcbc_pkg;

    localparam int BIN_W      = 63;               // card number width
    localparam int IN_TDATA_W = 64;               // input bus, padded to bytes
    localparam int NDIG       = 19;               // decimal digits held
    localparam int DIG_W      = 4;
    localparam int BCD_W      = NDIG * DIG_W;
    localparam int STEPS      = 3;                // shift steps per stage
    localparam int NSTG       = BIN_W / STEPS;    // conversion stages
    localparam int CNT_W      = 5;
    localparam int SUM_W      = 8;                // luhn sum, at most 171
    localparam int NGRP       = 4;                // partial sum groups
    localparam int GRP_SZ     = 5;                // digits per group
    localparam int BRAND_W    = 2;
    localparam int OUT_TDATA_W = 8;

    typedef logic [DIG_W-1:0] t_digit;
    typedef logic [CNT_W-1:0] t_count;
    typedef logic [SUM_W-1:0] t_sum;

    typedef enum logic [BRAND_W-1:0] {
        BRAND_INVALID    = 2'd0,
        BRAND_AMEX       = 2'd1,
        BRAND_MASTERCARD = 2'd2,
        BRAND_VISA       = 2'd3
    } t_brand;

    // conversion state: bcd digits above the binary bits still to shift in
    typedef struct packed {
        logic [BCD_W-1:0] bcd;
        logic [BIN_W-1:0] bin;
    } t_dd;

    // digit sum of twice the digit
    function automatic t_digit luhn_dbl(input t_digit d);
        t_digit r;
        unique case (d)
            4'd0: r = 4'd0;
            4'd1: r = 4'd2;
            4'd2: r = 4'd4;
            4'd3: r = 4'd6;
            4'd4: r = 4'd8;
            4'd5: r = 4'd1;
            4'd6: r = 4'd3;
            4'd7: r = 4'd5;
            4'd8: r = 4'd7;
            4'd9: r = 4'd9;
            default: r = 4'd0;
        endcase
        return r;
    endfunction

    // true when the sum is a multiple of ten
    function automatic logic is_mult10(input t_sum s);
        logic hit;
        hit = 1'b0;
        for (int k = 0; k < 26; k++) begin
            if (s == SUM_W'(k * 10)) begin
                hit = 1'b1;
            end
        end
        return hit;
    endfunction

endpackage

>>> sv/luhn_card_brand_check_core.sv
// ---------------------------------------------------------------------------
// luhn_card_brand_check_core
// pipelined luhn checksum and card brand decode of a binary card number
// ---------------------------------------------------------------------------
//
//  channel   dir  signals                          contents
//  -------   ---  -------------------------------  ------------------------------
//  s (in)    in   i_s_tvalid o_s_tready i_s_tdata  card_number [62:0], bit 63 zero
//  m (out)   out  o_m_tvalid i_m_tready o_m_tdata  brand [1:0], luhn_ok [2],
//                                                  digit_count [7:3]
//
//  one item enters per cycle while the pipe advances: 21 shift-add3 stages of
//  three bits each convert the 63 bits to 19 bcd digits, then 4 stages count
//  digits, sum the luhn terms and decode the brand
//  the last eval stage is the output register
//  the whole pipe advances when the output register is empty or being taken,
//  so a stall freezes every stage and nothing is lost or repeated
//  reset (synchronous, active low) clears only the valid bits
//
module luhn_card_brand_check_core (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_s_tvalid,
    output logic                             o_s_tready,
    input  logic [lcbc_pkg::IN_TDATA_W-1:0]  i_s_tdata,   // card_number[62:0], pad[63]
    output logic                             o_m_tvalid,
    input  logic                             i_m_tready,
    output logic [lcbc_pkg::OUT_TDATA_W-1:0] o_m_tdata    // brand[1:0], luhn_ok[2],
                                                          // digit_count[7:3]
);

    // pipeline advance
    logic en;

    // conversion chain: index 0 is the input side
    logic          stg_valid [lcbc_pkg::NSTG+1];
    lcbc_pkg::t_dd stg_data  [lcbc_pkg::NSTG+1];

    lcbc_pkg::t_brand brand;
    logic             luhn_ok;
    lcbc_pkg::t_count digit_count;

    assign en         = !o_m_tvalid || i_m_tready;
    assign o_s_tready = en;

    // bcd starts empty, binary bits shift in msb first
    assign stg_valid[0]    = i_s_tvalid;
    assign stg_data[0].bcd = '0;
    assign stg_data[0].bin = i_s_tdata[lcbc_pkg::BIN_W-1:0];

    for (genvar g = 0; g < lcbc_pkg::NSTG; g++) begin : g_dabble
        lcbc_dabble_stage u_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_valid (stg_valid[g]),
            .i_data  (stg_data[g]),
            .o_valid (stg_valid[g+1]),
            .o_data  (stg_data[g+1])
        );
    end

    // digit evaluation, ends in the output register
    lcbc_digit_eval u_eval (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_en      (en),
        .i_valid   (stg_valid[lcbc_pkg::NSTG]),
        .i_bcd     (stg_data[lcbc_pkg::NSTG].bcd),
        .o_valid   (o_m_tvalid),
        .o_brand   (brand),
        .o_luhn_ok (luhn_ok),
        .o_count   (digit_count)
    );

    assign o_m_tdata = {digit_count, luhn_ok, brand};

    // a brand is only given to a number that passes luhn
    a_brand_needs_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && brand != lcbc_pkg::BRAND_INVALID |-> luhn_ok)
        else $error("brand set on luhn failure");

    // brand agrees with the digit count
    a_brand_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |->
            (brand != lcbc_pkg::BRAND_AMEX || digit_count == 5'd15) &&
            (brand != lcbc_pkg::BRAND_MASTERCARD || digit_count == 5'd16) &&
            (brand != lcbc_pkg::BRAND_VISA || digit_count == 5'd13
                                           || digit_count == 5'd16))
        else $error("brand does not match digit count");

    // 63 bits never need more than 19 digits
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> digit_count <= 5'd19)
        else $error("digit count out of range");

    // zero has no digits, passes luhn and has no brand
    a_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && digit_count == 5'd0 |->
            luhn_ok && brand == lcbc_pkg::BRAND_INVALID)
        else $error("zero value misreported");

endmodule

>>> sv/lcbc_dabble_stage.sv
// ---------------------------------------------------------------------------
// lcbc_dabble_stage
// one register stage of the binary to bcd shifter, lcbc_pkg::STEPS shift steps deep
// ---------------------------------------------------------------------------
module lcbc_dabble_stage (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    input  logic            i_valid,
    input  lcbc_pkg::t_dd   i_data,
    output logic            o_valid,
    output lcbc_pkg::t_dd   o_data
);

    logic          r_valid;
    lcbc_pkg::t_dd r_data;
    lcbc_pkg::t_dd n_data;

    always_comb begin
        n_data = i_data;
        for (int s = 0; s < lcbc_pkg::STEPS; s++) begin
            for (int d = 0; d < lcbc_pkg::NDIG; d++) begin
                if (n_data.bcd[d*lcbc_pkg::DIG_W +: lcbc_pkg::DIG_W] >= 4'd5) begin
                    n_data.bcd[d*lcbc_pkg::DIG_W +: lcbc_pkg::DIG_W] =
                        n_data.bcd[d*lcbc_pkg::DIG_W +: lcbc_pkg::DIG_W] + 4'd3;
                end
            end
            n_data = n_data << 1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

>>> sv/lcbc_digit_eval.sv
// ---------------------------------------------------------------------------
// lcbc_digit_eval
// digit count, leading digits, luhn sum and brand decode over four stages
// ---------------------------------------------------------------------------
module lcbc_digit_eval (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_en,
    input  logic                       i_valid,
    input  logic [lcbc_pkg::BCD_W-1:0] i_bcd,
    output logic                       o_valid,
    output lcbc_pkg::t_brand           o_brand,
    output logic                       o_luhn_ok,
    output lcbc_pkg::t_count           o_count
);

    // stage 1: count, leading digits, luhn terms
    logic             [3:0] r_valid;
    lcbc_pkg::t_count       r1_cnt, n1_cnt;
    lcbc_pkg::t_digit       r1_hi, n1_hi, r1_lo, n1_lo;
    lcbc_pkg::t_digit [lcbc_pkg::NDIG-1:0] r1_term, n1_term;
    // stage 2: partial sums
    lcbc_pkg::t_count       r2_cnt;
    lcbc_pkg::t_digit       r2_hi, r2_lo;
    lcbc_pkg::t_sum   [lcbc_pkg::NGRP-1:0] r2_part, n2_part;
    // stage 3: full sum
    lcbc_pkg::t_count       r3_cnt;
    lcbc_pkg::t_digit       r3_hi, r3_lo;
    lcbc_pkg::t_sum         r3_sum, n3_sum;
    // stage 4: result
    lcbc_pkg::t_count       r4_cnt;
    lcbc_pkg::t_brand       r4_brand, n4_brand;
    logic                   r4_ok, n4_ok;
    lcbc_pkg::t_digit       dig;

    always_comb begin
        n1_cnt  = '0;
        n1_hi   = '0;
        n1_lo   = '0;
        dig     = '0;
        n1_term = '0;
        for (int k = 0; k < lcbc_pkg::NDIG; k++) begin
            dig = i_bcd[k*lcbc_pkg::DIG_W +: lcbc_pkg::DIG_W];
            n1_term[k] = (k % 2 == 1) ? lcbc_pkg::luhn_dbl(dig) : dig;
            if (dig != 4'd0) begin
                n1_cnt = lcbc_pkg::CNT_W'(k + 1);
                n1_hi  = dig;
                n1_lo  = (k > 0) ? i_bcd[(k-1)*lcbc_pkg::DIG_W +: lcbc_pkg::DIG_W] : 4'd0;
            end
        end
    end

    always_comb begin
        n2_part = '0;
        for (int g = 0; g < lcbc_pkg::NGRP; g++) begin
            for (int j = 0; j < lcbc_pkg::GRP_SZ; j++) begin
                if (g * lcbc_pkg::GRP_SZ + j < lcbc_pkg::NDIG) begin
                    n2_part[g] = n2_part[g]
                        + lcbc_pkg::SUM_W'(r1_term[g * lcbc_pkg::GRP_SZ + j]);
                end
            end
        end
    end

    always_comb begin
        n3_sum = '0;
        for (int g = 0; g < lcbc_pkg::NGRP; g++) begin
            n3_sum = n3_sum + r2_part[g];
        end
    end

    always_comb begin
        n4_ok    = lcbc_pkg::is_mult10(r3_sum);
        n4_brand = lcbc_pkg::BRAND_INVALID;
        if (n4_ok) begin
            priority if (r3_cnt == 5'd15 && r3_hi == 4'd3
                         && (r3_lo == 4'd4 || r3_lo == 4'd7)) begin
                n4_brand = lcbc_pkg::BRAND_AMEX;
            end else if (r3_cnt == 5'd16 && r3_hi == 4'd5
                         && r3_lo >= 4'd1 && r3_lo <= 4'd5) begin
                n4_brand = lcbc_pkg::BRAND_MASTERCARD;
            end else if ((r3_cnt == 5'd13 || r3_cnt == 5'd16) && r3_hi == 4'd4) begin
                n4_brand = lcbc_pkg::BRAND_VISA;
            end else begin
                n4_brand = lcbc_pkg::BRAND_INVALID;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_en) begin
            r_valid <= {r_valid[2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_cnt   <= n1_cnt;
            r1_hi    <= n1_hi;
            r1_lo    <= n1_lo;
            r1_term  <= n1_term;
            r2_cnt   <= r1_cnt;
            r2_hi    <= r1_hi;
            r2_lo    <= r1_lo;
            r2_part  <= n2_part;
            r3_cnt   <= r2_cnt;
            r3_hi    <= r2_hi;
            r3_lo    <= r2_lo;
            r3_sum   <= n3_sum;
            r4_cnt   <= r3_cnt;
            r4_ok    <= n4_ok;
            r4_brand <= n4_brand;
        end
    end

    assign o_valid   = r_valid[3];
    assign o_brand   = r4_brand;
    assign o_luhn_ok = r4_ok;
    assign o_count   = r4_cnt;

endmodule
